// File: rtl/fsts_pkg.sv
// Shared types, constants and helper functions of the TCP flow statistics table.
// No dependencies; the top level and the testbench import this package.
`default_nettype none

package fsts_pkg;

  // Table geometry.
  localparam int FLOW_SLOTS = 256;
  localparam int SLOT_W     = $clog2(FLOW_SLOTS);
  localparam int CNT_W      = 12;
  localparam int REC_WORDS  = 8;

  // Bit positions in the TCP flags byte.
  localparam int FL_FIN = 0;
  localparam int FL_SYN = 1;
  localparam int FL_RST = 2;
  localparam int FL_PSH = 3;
  localparam int FL_ACK = 4;
  localparam int FL_URG = 5;
  localparam int FL_ECE = 6;
  localparam int FL_CWR = 7;

  // Status codes of the per-packet status item.
  typedef enum logic [1:0] {
    ST_UPDATED = 2'd0,
    ST_NEW     = 2'd1,
    ST_REUSED  = 2'd2,
    ST_DROPPED = 2'd3
  } status_t;

  // One packet header summary.
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port_in;
    logic [15:0] dst_port_in;
    logic [3:0]  ip_header_words;
    logic [3:0]  tcp_header_words;
    logic [15:0] ip_total_length;
    logic [7:0]  tcp_flag_bits;
  } in_item_t;

  // One result item: a status item or one record word.
  typedef struct packed {
    logic        item_kind;
    logic [7:0]  flow_slot;
    logic [1:0]  status_code;
    logic        will_export;
    logic [2:0]  word_index;
    logic [63:0] record_word;
    logic        last_item;
  } out_item_t;

  // Flow key as stored in the key memory.
  typedef struct packed {
    logic [63:0] addrs;
    logic [31:0] ports;
  } key_t;

  // Per-flow statistics as stored in the statistics memory, with the live flag.
  typedef struct packed {
    logic        live;
    logic        fin_seen;
    logic        await_ack;
    logic [31:0] pkt_total;
    logic [63:0] dir_counts;
    logic [31:0] hdr_ext;
    logic [63:0] pay_ext;
    logic [63:0] pay_tot;
    logic [63:0] flags0;
    logic [63:0] flags1;
  } stats_t;

  // Saturating 32-bit add.
  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Saturating increment of a flag counter.
  function automatic logic [CNT_W-1:0] inc_cnt(input logic [CNT_W-1:0] a);
    return (&a) ? a : a + 1'b1;
  endfunction

  // Minimum where a stored zero means unset.
  function automatic logic [15:0] upd_min(input logic [15:0] cur, input logic [15:0] x);
    return ((cur > x) || (cur == 16'd0)) ? x : cur;
  endfunction

  function automatic logic [15:0] upd_max(input logic [15:0] cur, input logic [15:0] x);
    return (cur < x) ? x : cur;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tcp_flow_statistics_table_unit.sv
// TCP flow statistics table: top level with the lookup and update sequencer.
// Depends on fsts_pkg and instantiates fsts_ram for keys, statistics and freed slots.
//
// Usage:
//   The in_ channel takes one packet header summary per transfer (in_valid,
//   in_ready, in_data). The out_ channel delivers result items (out_valid,
//   out_ready, out_data): one status item per packet, followed by eight
//   record words when the packet closes its flow. last_item marks the final
//   item of a packet. There are no configuration registers.
//   A packet is handled one at a time. The lookup walks the used slots in
//   order through the key memory, with a read state (S_KRD) and a compare
//   state (S_KCMP) per slot visited, up to the hit or through all used
//   slots on a miss; a reused slot passes one more state (S_FGET). Record
//   words then follow the status item at one per cycle as long as the
//   receiver keeps out_ready high.
//   The block takes the next packet as soon as the last item is in the
//   output register, even while that item still waits for out_ready.
//   A stalled receiver holds the output register and the sequencer waits.
//   Synchronous reset clears the slot and freed-slot counters and the
//   handshake state. Live flags sit in the statistics memory; only slots
//   below the used count are searched, and each is written when it opens,
//   so no clearing pass is needed afterwards.
`default_nettype none

module tcp_flow_statistics_table_unit
  import fsts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_KRD  = 7'b0000010,
    S_KCMP = 7'b0000100,
    S_MISS = 7'b0001000,
    S_FGET = 7'b0010000,
    S_MOD  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Packet registers.
  in_item_t    pkt_r;
  logic [15:0] pay_r;
  logic [7:0]  hdr_r;

  // Sequencer registers.
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W:0]   slots_used_r, slots_used_nxt;
  logic [SLOT_W-1:0] fifo_rd_ptr_r, fifo_rd_ptr_nxt;
  logic [SLOT_W-1:0] fifo_wr_ptr_r, fifo_wr_ptr_nxt;
  logic [SLOT_W:0]   fifo_fill_r, fifo_fill_nxt;
  logic              new_r, new_nxt;
  logic              fwd_r, fwd_nxt;
  logic              drop_r, drop_nxt;
  logic              close_r, close_nxt;
  status_t           status_r, status_nxt;
  logic [3:0]        k_r, k_nxt;
  key_t              rec_key_r, rec_key_nxt;
  stats_t            rec_r, rec_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  // Memory ports.
  logic              key_we, key_re, st_we, st_re, ff_we, ff_re;
  logic [SLOT_W-1:0] key_raddr;
  key_t              key_wdata, key_rdata;
  stats_t            st_rdata, upd;
  logic [SLOT_W-1:0] ff_rdata;
  logic              upd_close;

  // Input-derived values.
  logic [6:0]  hdr_sum;
  logic [15:0] pay_in;
  key_t        fwd_key, bwd_key;

  assign hdr_sum = {1'b0, in_data.ip_header_words, 2'b00}
                 + {1'b0, in_data.tcp_header_words, 2'b00};
  assign pay_in  = (in_data.ip_total_length > {9'd0, hdr_sum})
                 ? in_data.ip_total_length - {9'd0, hdr_sum} : 16'd0;
  assign fwd_key = '{addrs: {pkt_r.src_addr, pkt_r.dst_addr},
                     ports: {pkt_r.src_port_in, pkt_r.dst_port_in}};
  assign bwd_key = '{addrs: {pkt_r.dst_addr, pkt_r.src_addr},
                     ports: {pkt_r.dst_port_in, pkt_r.src_port_in}};

  fsts_ram #(.W($bits(key_t)), .DEPTH(FLOW_SLOTS)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(slot_r), .wdata(key_wdata),
    .re(key_re), .raddr(key_raddr), .rdata_r(key_rdata)
  );

  fsts_ram #(.W($bits(stats_t)), .DEPTH(FLOW_SLOTS)) u_stats_ram (
    .clk(clk), .we(st_we), .waddr(slot_r), .wdata(upd),
    .re(st_re), .raddr(idx_r), .rdata_r(st_rdata)
  );

  fsts_ram #(.W(SLOT_W), .DEPTH(FLOW_SLOTS)) u_free_ram (
    .clk(clk), .we(ff_we), .waddr(fifo_wr_ptr_r), .wdata(slot_r),
    .re(ff_re), .raddr(fifo_rd_ptr_r), .rdata_r(ff_rdata)
  );

  // Statistics update of the matched or newly opened flow.
  always_comb begin
    stats_t      b;
    logic [15:0] hdr16;
    b     = new_r ? '0 : st_rdata;
    hdr16 = {8'd0, hdr_r};
    upd   = b;
    upd.pkt_total = sat_add32(b.pkt_total, 32'd1);
    if (fwd_r) begin
      upd.dir_counts[63:32] = sat_add32(b.dir_counts[63:32], 32'd1);
      upd.hdr_ext[31:24]    = 8'(upd_min({8'd0, b.hdr_ext[31:24]}, hdr16));
      upd.hdr_ext[23:16]    = 8'(upd_max({8'd0, b.hdr_ext[23:16]}, hdr16));
      upd.pay_ext[63:48]    = upd_min(b.pay_ext[63:48], pay_r);
      upd.pay_ext[47:32]    = upd_max(b.pay_ext[47:32], pay_r);
      upd.pay_tot[63:32]    = sat_add32(b.pay_tot[63:32], {16'd0, pay_r});
    end else begin
      upd.dir_counts[31:0]  = sat_add32(b.dir_counts[31:0], 32'd1);
      upd.hdr_ext[15:8]     = 8'(upd_min({8'd0, b.hdr_ext[15:8]}, hdr16));
      upd.hdr_ext[7:0]      = 8'(upd_max({8'd0, b.hdr_ext[7:0]}, hdr16));
      upd.pay_ext[31:16]    = upd_min(b.pay_ext[31:16], pay_r);
      upd.pay_ext[15:0]     = upd_max(b.pay_ext[15:0], pay_r);
      upd.pay_tot[31:0]     = sat_add32(b.pay_tot[31:0], {16'd0, pay_r});
    end
    // Flag counters.
    if (pkt_r.tcp_flag_bits[FL_FIN]) upd.flags0[11:0]  = inc_cnt(b.flags0[11:0]);
    if (pkt_r.tcp_flag_bits[FL_SYN]) upd.flags0[23:12] = inc_cnt(b.flags0[23:12]);
    if (pkt_r.tcp_flag_bits[FL_ACK]) upd.flags0[35:24] = inc_cnt(b.flags0[35:24]);
    if (pkt_r.tcp_flag_bits[FL_ECE]) upd.flags0[47:36] = inc_cnt(b.flags0[47:36]);
    if (pkt_r.tcp_flag_bits[FL_CWR]) upd.flags0[59:48] = inc_cnt(b.flags0[59:48]);
    if (pkt_r.tcp_flag_bits[FL_RST]) upd.flags1[11:0]  = inc_cnt(b.flags1[11:0]);
    if (pkt_r.tcp_flag_bits[FL_URG]) begin
      if (fwd_r) upd.flags1[23:12] = inc_cnt(b.flags1[23:12]);
      else       upd.flags1[35:24] = inc_cnt(b.flags1[35:24]);
    end
    if (pkt_r.tcp_flag_bits[FL_PSH]) begin
      if (fwd_r) upd.flags1[47:36] = inc_cnt(b.flags1[47:36]);
      else       upd.flags1[59:48] = inc_cnt(b.flags1[59:48]);
    end
    // Teardown tracking: a pending ACK closes before this packet's FIN counts.
    upd_close = 1'b0;
    if (new_r) begin
      upd.fin_seen  = 1'b0;
      upd.await_ack = 1'b0;
      upd_close     = pkt_r.tcp_flag_bits[FL_RST];
    end else if (pkt_r.tcp_flag_bits[FL_ACK] && b.await_ack) begin
      upd_close = 1'b1;
    end else begin
      if (pkt_r.tcp_flag_bits[FL_FIN]) begin
        if (b.fin_seen) upd.await_ack = 1'b1;
        upd.fin_seen = 1'b1;
      end
      upd_close = pkt_r.tcp_flag_bits[FL_RST];
    end
    // A closing flow leaves the table.
    upd.live = !upd_close;
  end

  // Sequencer.
  always_comb begin
    logic [SLOT_W:0] idx_inc;
    logic            hit_f, hit_b;
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    slot_nxt        = slot_r;
    slots_used_nxt  = slots_used_r;
    fifo_rd_ptr_nxt = fifo_rd_ptr_r;
    fifo_wr_ptr_nxt = fifo_wr_ptr_r;
    fifo_fill_nxt   = fifo_fill_r;
    new_nxt         = new_r;
    fwd_nxt         = fwd_r;
    drop_nxt        = drop_r;
    close_nxt       = close_r;
    status_nxt      = status_r;
    k_nxt           = k_r;
    rec_key_nxt     = rec_key_r;
    rec_nxt         = rec_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;
    key_we          = 1'b0;
    key_re          = 1'b0;
    key_raddr       = idx_r;
    key_wdata       = fwd_key;
    st_we           = 1'b0;
    st_re           = 1'b0;
    ff_we           = 1'b0;
    ff_re           = 1'b0;
    in_ready        = (state_r == S_IDLE);
    idx_inc         = {1'b0, idx_r} + 1'b1;
    hit_f           = (key_rdata == fwd_key);
    hit_b           = (key_rdata == bwd_key);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt   = '0;
          drop_nxt  = 1'b0;
          close_nxt = 1'b0;
          k_nxt     = '0;
          state_nxt = (slots_used_r == '0) ? S_MISS : S_KRD;
        end
      end
      S_KRD: begin
        // Stats and live flag are fetched alongside the key, so a hit goes
        // straight to the update.
        key_re    = 1'b1;
        st_re     = 1'b1;
        state_nxt = S_KCMP;
      end
      S_KCMP: begin
        if (st_rdata.live && (hit_f || hit_b)) begin
          slot_nxt    = idx_r;
          fwd_nxt     = hit_f;
          new_nxt     = 1'b0;
          status_nxt  = ST_UPDATED;
          rec_key_nxt = key_rdata;
          state_nxt   = S_MOD;
        end else if (idx_inc == slots_used_r) begin
          state_nxt = S_MISS;
        end else begin
          idx_nxt   = idx_inc[SLOT_W-1:0];
          state_nxt = S_KRD;
        end
      end
      S_MISS: begin
        fwd_nxt     = 1'b1;
        new_nxt     = 1'b1;
        rec_key_nxt = fwd_key;
        if (fifo_fill_r != '0) begin
          ff_re           = 1'b1;
          fifo_rd_ptr_nxt = fifo_rd_ptr_r + 1'b1;
          fifo_fill_nxt   = fifo_fill_r - 1'b1;
          status_nxt      = ST_REUSED;
          state_nxt       = S_FGET;
        end else if (slots_used_r < (SLOT_W + 1)'(FLOW_SLOTS)) begin
          slot_nxt       = slots_used_r[SLOT_W-1:0];
          slots_used_nxt = slots_used_r + 1'b1;
          status_nxt     = ST_NEW;
          state_nxt      = S_MOD;
        end else begin
          drop_nxt   = 1'b1;
          status_nxt = ST_DROPPED;
          state_nxt  = S_EMIT;
        end
      end
      S_FGET: begin
        slot_nxt  = ff_rdata;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        st_we     = 1'b1;
        key_we    = new_r;
        rec_nxt   = upd;
        close_nxt = upd_close;
        if (upd_close && (fifo_fill_r < (SLOT_W + 1)'(FLOW_SLOTS))) begin
          ff_we           = 1'b1;
          fifo_wr_ptr_nxt = fifo_wr_ptr_r + 1'b1;
          fifo_fill_nxt   = fifo_fill_nxt + 1'b1;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          if (k_r == '0) begin
            out_data_nxt.flow_slot   = drop_r ? 8'd0 : 8'(slot_r);
            out_data_nxt.status_code = status_r;
            out_data_nxt.will_export = close_r;
            out_data_nxt.last_item   = !close_r;
          end else begin
            out_data_nxt.item_kind  = 1'b1;
            out_data_nxt.flow_slot  = 8'(slot_r);
            out_data_nxt.word_index = 3'(k_r - 1'b1);
            out_data_nxt.last_item  = (k_r == 4'(REC_WORDS));
            case (k_r)
              4'd1:    out_data_nxt.record_word = rec_key_r.addrs;
              4'd2:    out_data_nxt.record_word = {rec_key_r.ports, rec_r.pkt_total};
              4'd3:    out_data_nxt.record_word = rec_r.dir_counts;
              4'd4:    out_data_nxt.record_word = {32'd0, rec_r.hdr_ext};
              4'd5:    out_data_nxt.record_word = rec_r.pay_ext;
              4'd6:    out_data_nxt.record_word = rec_r.pay_tot;
              4'd7:    out_data_nxt.record_word = rec_r.flags0;
              default: out_data_nxt.record_word = rec_r.flags1;
            endcase
          end
          if (out_data_nxt.last_item) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      slots_used_r  <= '0;
      fifo_rd_ptr_r <= '0;
      fifo_wr_ptr_r <= '0;
      fifo_fill_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      slots_used_r  <= slots_used_nxt;
      fifo_rd_ptr_r <= fifo_rd_ptr_nxt;
      fifo_wr_ptr_r <= fifo_wr_ptr_nxt;
      fifo_fill_r   <= fifo_fill_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pkt_r <= in_data;
      pay_r <= pay_in;
      hdr_r <= {2'b00, in_data.tcp_header_words, 2'b00};
    end
    idx_r      <= idx_nxt;
    slot_r     <= slot_nxt;
    new_r      <= new_nxt;
    fwd_r      <= fwd_nxt;
    drop_r     <= drop_nxt;
    close_r    <= close_nxt;
    status_r   <= status_nxt;
    k_r        <= k_nxt;
    rec_key_r  <= rec_key_nxt;
    rec_r      <= rec_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/fsts_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the key, statistics and freed-slot memories; no dependencies.
`default_nettype none

module fsts_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata_r
);

  logic [W-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// File: verif/tb_tcp_flow_statistics_table_unit.sv
// Self-checking testbench for the TCP flow statistics table top level.
// Depends on fsts_pkg and tcp_flow_statistics_table_unit; holds its own flow table predictor.
`timescale 1ns / 100ps

import fsts_pkg::*;

// Flow table predictor with the queue of expected result items.
class flow_table_model;

  logic [63:0] key_addrs [FLOW_SLOTS];
  logic [31:0] key_ports [FLOW_SLOTS];
  bit          live      [FLOW_SLOTS];
  bit          fin_seen  [FLOW_SLOTS];
  bit          await_ack [FLOW_SLOTS];
  logic [31:0] pkt_total [FLOW_SLOTS];
  logic [63:0] dir_cnt   [FLOW_SLOTS];
  logic [31:0] hdr_ext   [FLOW_SLOTS];
  logic [63:0] pay_ext   [FLOW_SLOTS];
  logic [63:0] pay_tot   [FLOW_SLOTS];
  logic [63:0] flag_cnt  [2*FLOW_SLOTS];
  int          slots_used;
  int          freed_q[$];
  out_item_t   expected_items[$];
  int          mismatches;

  function new();
    for (int i = 0; i < FLOW_SLOTS; i++) live[i] = 0;
    slots_used = 0;
    mismatches = 0;
  endfunction

  function logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // A stored minimum of zero counts as unset.
  function logic [15:0] min_unset(logic [15:0] cur, logic [15:0] x);
    return (cur > x || cur == 16'd0) ? x : cur;
  endfunction

  function logic [15:0] max_of(logic [15:0] cur, logic [15:0] x);
    return (cur < x) ? x : cur;
  endfunction

  function void bump_flag(int slot, int k);
    int          wi;
    int          sh;
    logic [63:0] w;
    logic [63:0] v;
    wi = 2 * slot + k / 5;
    sh = (k % 5) * CNT_W;
    w = flag_cnt[wi];
    v = (w >> sh) & 64'hFFF;
    if (v != 64'hFFF) v = v + 1;
    flag_cnt[wi] = (w & ~(64'hFFF << sh)) | (v << sh);
  endfunction

  // Direction counts, extremes, totals and flag counters for one packet.
  function void accumulate(int slot, bit fwd, logic [7:0] hdr, logic [15:0] pay,
                           logic [7:0] fl);
    logic [63:0] d;
    logic [31:0] h;
    logic [63:0] p;
    logic [63:0] t;
    d = dir_cnt[slot];
    h = hdr_ext[slot];
    p = pay_ext[slot];
    t = pay_tot[slot];
    if (fwd) begin
      d[63:32] = add_sat(d[63:32], 32'd1);
      h[31:24] = 8'(min_unset({8'd0, h[31:24]}, {8'd0, hdr}));
      h[23:16] = 8'(max_of({8'd0, h[23:16]}, {8'd0, hdr}));
      p[63:48] = min_unset(p[63:48], pay);
      p[47:32] = max_of(p[47:32], pay);
      t[63:32] = add_sat(t[63:32], {16'd0, pay});
    end else begin
      d[31:0]  = add_sat(d[31:0], 32'd1);
      h[15:8]  = 8'(min_unset({8'd0, h[15:8]}, {8'd0, hdr}));
      h[7:0]   = 8'(max_of({8'd0, h[7:0]}, {8'd0, hdr}));
      p[31:16] = min_unset(p[31:16], pay);
      p[15:0]  = max_of(p[15:0], pay);
      t[31:0]  = add_sat(t[31:0], {16'd0, pay});
    end
    dir_cnt[slot] = d;
    hdr_ext[slot] = h;
    pay_ext[slot] = p;
    pay_tot[slot] = t;
    if (fl[FL_FIN]) bump_flag(slot, 0);
    if (fl[FL_SYN]) bump_flag(slot, 1);
    if (fl[FL_ACK]) bump_flag(slot, 2);
    if (fl[FL_ECE]) bump_flag(slot, 3);
    if (fl[FL_CWR]) bump_flag(slot, 4);
    if (fl[FL_RST]) bump_flag(slot, 5);
    if (fl[FL_URG]) bump_flag(slot, fwd ? 6 : 7);
    if (fl[FL_PSH]) bump_flag(slot, fwd ? 8 : 9);
  endfunction

  // Notes one accepted packet and queues the items it causes.
  function out_item_t note_packet(in_item_t pk);
    logic [7:0]  iph;
    logic [7:0]  tcph;
    logic [16:0] hl;
    logic [15:0] pay;
    logic [63:0] fa;
    logic [63:0] ba;
    logic [31:0] fp;
    logic [31:0] bp;
    logic [63:0] words [8];
    int          slot;
    bit          found;
    bit          fwd;
    bit          closing;
    out_item_t   st;
    out_item_t   rec;
    iph  = {2'b0, pk.ip_header_words, 2'b0};
    tcph = {2'b0, pk.tcp_header_words, 2'b0};
    hl   = {9'd0, iph} + {9'd0, tcph};
    pay  = ({1'b0, pk.ip_total_length} > hl) ? 16'(pk.ip_total_length - hl) : 16'd0;
    fa = {pk.src_addr, pk.dst_addr};
    ba = {pk.dst_addr, pk.src_addr};
    fp = {pk.src_port_in, pk.dst_port_in};
    bp = {pk.dst_port_in, pk.src_port_in};
    slot = 0;
    found = 0;
    fwd = 1;
    closing = 0;
    st = '0;
    for (int i = 0; i < slots_used && !found; i++) begin
      if (live[i]) begin
        if (key_addrs[i] == fa && key_ports[i] == fp) begin
          found = 1; fwd = 1; slot = i;
        end else if (key_addrs[i] == ba && key_ports[i] == bp) begin
          found = 1; fwd = 0; slot = i;
        end
      end
    end
    if (found) begin
      st.status_code = ST_UPDATED;
      pkt_total[slot] = add_sat(pkt_total[slot], 32'd1);
      accumulate(slot, fwd, tcph, pay, pk.tcp_flag_bits);
      // An ACK while awaiting it closes before this packet's FIN counts.
      if (pk.tcp_flag_bits[FL_ACK] && await_ack[slot]) begin
        closing = 1;
      end else begin
        if (pk.tcp_flag_bits[FL_FIN]) begin
          if (fin_seen[slot]) await_ack[slot] = 1;
          fin_seen[slot] = 1;
        end
        if (pk.tcp_flag_bits[FL_RST]) closing = 1;
      end
    end else begin
      if (freed_q.size() > 0) begin
        slot = freed_q.pop_front();
        st.status_code = ST_REUSED;
      end else if (slots_used < FLOW_SLOTS) begin
        slot = slots_used;
        slots_used++;
        st.status_code = ST_NEW;
      end else begin
        st.status_code = ST_DROPPED;
        st.last_item = 1;
        expected_items.push_back(st);
        return st;
      end
      key_addrs[slot] = fa;
      key_ports[slot] = fp;
      live[slot] = 1;
      fin_seen[slot] = 0;
      await_ack[slot] = 0;
      pkt_total[slot] = 32'd1;
      dir_cnt[slot] = '0;
      hdr_ext[slot] = '0;
      pay_ext[slot] = '0;
      pay_tot[slot] = '0;
      flag_cnt[2*slot] = '0;
      flag_cnt[2*slot+1] = '0;
      accumulate(slot, 1, tcph, pay, pk.tcp_flag_bits);
      if (pk.tcp_flag_bits[FL_RST]) closing = 1;
    end
    st.flow_slot = 8'(slot);
    st.will_export = closing;
    st.last_item = !closing;
    expected_items.push_back(st);
    if (closing) begin
      words[0] = key_addrs[slot];
      words[1] = {key_ports[slot], pkt_total[slot]};
      words[2] = dir_cnt[slot];
      words[3] = {32'd0, hdr_ext[slot]};
      words[4] = pay_ext[slot];
      words[5] = pay_tot[slot];
      words[6] = flag_cnt[2*slot];
      words[7] = flag_cnt[2*slot+1];
      for (int k = 0; k < 8; k++) begin
        rec = '0;
        rec.item_kind = 1;
        rec.flow_slot = 8'(slot);
        rec.word_index = 3'(k);
        rec.record_word = words[k];
        rec.last_item = (k == 7);
        expected_items.push_back(rec);
      end
      live[slot] = 0;
      if (freed_q.size() < FLOW_SLOTS) freed_q.push_back(slot);
    end
    return st;
  endfunction

  // Compares one accepted result item with the oldest expectation.
  function void check_item(out_item_t got);
    out_item_t want;
    if (expected_items.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item %h", got);
      return;
    end
    want = expected_items.pop_front();
    if (got.item_kind != want.item_kind || got.flow_slot != want.flow_slot ||
        got.status_code != want.status_code || got.will_export != want.will_export ||
        got.word_index != want.word_index || got.record_word != want.record_word ||
        got.last_item != want.last_item) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch (exp/act): kind %0d/%0d slot %0d/%0d status %0d/%0d",
                 want.item_kind, got.item_kind, want.flow_slot, got.flow_slot,
                 want.status_code, got.status_code);
        $display("  export %0d/%0d idx %0d/%0d word %h/%h last %0d/%0d",
                 want.will_export, got.will_export, want.word_index, got.word_index,
                 want.record_word, got.record_word, want.last_item, got.last_item);
      end
    end
  endfunction
endclass

module tb_tcp_flow_statistics_table_unit;
  import fsts_pkg::*;

  localparam logic [7:0] F_FIN = 8'h01;
  localparam logic [7:0] F_SYN = 8'h02;
  localparam logic [7:0] F_RST = 8'h04;
  localparam logic [7:0] F_PSH = 8'h08;
  localparam logic [7:0] F_ACK = 8'h10;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  flow_table_model flow_model;
  in_item_t        open_flows[$];
  bit              no_idle;
  int              ready_hold;
  out_item_t       last_status;

  tcp_flow_statistics_table_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("tb_tcp_flow_statistics_table_unit: errors");
    $finish;
  end

  // Result side: check every transfer and stall at random.
  initial begin
    out_ready <= 0;
    ready_hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        flow_model.check_item(out_data);
        ready_hold = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (ready_hold > 0) begin
        out_ready <= 0;
        ready_hold--;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // Presents one packet after a random gap and waits for its transfer.
  task automatic send_packet(in_item_t pk);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= pk;
    do @(posedge clk); while (!in_ready);
    last_status = flow_model.note_packet(pk);
  endtask

  function automatic in_item_t fresh_tuple();
    in_item_t pk;
    pk = '0;
    pk.src_addr = $urandom;
    pk.dst_addr = $urandom;
    pk.src_port_in = 16'($urandom_range(0, 65535));
    pk.dst_port_in = 16'($urandom_range(0, 65535));
    return pk;
  endfunction

  // Packet of a known flow in either direction with random lengths.
  function automatic in_item_t flow_packet(in_item_t base, bit reverse, logic [7:0] fl);
    in_item_t pk;
    pk = base;
    if (reverse) begin
      pk.src_addr = base.dst_addr;
      pk.dst_addr = base.src_addr;
      pk.src_port_in = base.dst_port_in;
      pk.dst_port_in = base.src_port_in;
    end
    pk.ip_header_words = 4'($urandom_range(0, 15));
    pk.tcp_header_words = 4'($urandom_range(0, 15));
    pk.ip_total_length = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                         16'($urandom_range(0, 1600));
    pk.tcp_flag_bits = fl;
    return pk;
  endfunction

  task automatic send_fixed(in_item_t base, bit reverse, logic [3:0] ihw, logic [3:0] thw,
                            logic [15:0] len, logic [7:0] fl);
    in_item_t pk;
    pk = flow_packet(base, reverse, fl);
    pk.ip_header_words = ihw;
    pk.tcp_header_words = thw;
    pk.ip_total_length = len;
    send_packet(pk);
  endtask

  // Opens a flow and keeps it for later traffic unless it closed or was dropped.
  task automatic open_flow(logic [7:0] fl);
    in_item_t base;
    base = fresh_tuple();
    send_packet(flow_packet(base, 0, fl));
    if (last_status.status_code != ST_DROPPED && !last_status.will_export)
      open_flows.push_back(base);
  endtask

  // One packet of a random live flow, removed from the list when it closes.
  task automatic flow_step();
    int       idx;
    int       r;
    logic [7:0] fl;
    idx = $urandom_range(0, open_flows.size() - 1);
    r = $urandom_range(0, 99);
    if (r < 6)       fl = F_RST | 8'($urandom);
    else if (r < 35) fl = F_FIN | (($urandom_range(0, 1) == 1) ? F_ACK : 8'h00);
    else             fl = (8'($urandom) & ~(F_FIN | F_RST)) | F_ACK;
    send_packet(flow_packet(open_flows[idx], $urandom_range(0, 1), fl));
    if (last_status.will_export) open_flows.delete(idx);
  endtask

  initial begin
    in_item_t a;
    in_item_t b;
    in_item_t c;
    in_item_t z;
    in_item_t noise;
    int       guard;
    flow_model = new();
    no_idle = 0;
    rst_n <= 0;
    in_valid <= 0;
    in_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // Directed: extremes, both directions, unset minimum, negative payload.
    z = '0;
    send_fixed(z, 0, 4'd0, 4'd0, 16'd0, F_SYN);
    send_fixed(z, 1, 4'd15, 4'd15, 16'hFFFF, F_ACK | F_PSH | 8'h20);
    send_fixed(z, 0, 4'd15, 4'd15, 16'd10, F_ACK | 8'hC0);
    send_fixed(z, 1, 4'd5, 4'd5, 16'd100, F_ACK);
    send_fixed(z, 0, 4'd5, 4'd8, 16'd500, F_FIN | F_ACK);
    send_fixed(z, 1, 4'd5, 4'd5, 16'd40, F_FIN | F_ACK);
    send_fixed(z, 0, 4'd5, 4'd5, 16'd40, F_ACK);
    // All-ones packet: opens and closes at once on RST.
    a = '1;
    send_fixed(a, 0, 4'd15, 4'd15, 16'hFFFF, 8'hFF);
    // Reused slot; ACK with FIN while awaiting ACK closes first.
    b = fresh_tuple();
    send_fixed(b, 0, 4'd5, 4'd5, 16'd60, F_SYN | F_FIN);
    send_fixed(b, 1, 4'd5, 4'd5, 16'd60, F_FIN);
    send_fixed(b, 0, 4'd5, 4'd5, 16'd60, F_FIN);
    send_fixed(b, 1, 4'd5, 4'd5, 16'd60, F_FIN | F_ACK);
    // RST on an update, and the ACK-before-second-FIN case staying open.
    c = fresh_tuple();
    send_fixed(c, 0, 4'd5, 4'd10, 16'd80, F_SYN);
    send_fixed(c, 1, 4'd5, 4'd10, 16'd20, F_ACK | F_FIN);
    send_fixed(c, 0, 4'd5, 4'd10, 16'd90, F_ACK);
    send_fixed(c, 1, 4'd6, 4'd7, 16'd0, F_RST | F_ACK);

    // Random flow traffic with some noise packets.
    for (int n = 0; n < 30; n++) begin
      no_idle = (n / 10) % 3 == 2;
      if (open_flows.size() < 3 || $urandom_range(0, 9) == 0) begin
        open_flow(F_SYN | (($urandom_range(0, 7) == 0) ? F_FIN : 8'h00));
      end else if ($urandom_range(0, 11) == 0) begin
        noise = fresh_tuple();
        noise = flow_packet(noise, 0, 8'($urandom));
        send_packet(noise);
      end else begin
        flow_step();
      end
    end

    // Fill the table until packets are dropped, then free and reuse a few slots.
    no_idle = 0;
    guard = 0;
    while (last_status.status_code != ST_DROPPED && guard < 300) begin
      open_flow(F_SYN);
      guard++;
    end
    repeat (3) open_flow(F_SYN | 8'($urandom));
    repeat (3) begin
      if (open_flows.size() > 0) begin
        send_packet(flow_packet(open_flows[0], 1, F_RST));
        void'(open_flows.pop_front());
      end
    end
    repeat (4) open_flow(F_SYN);
    repeat (20) if (open_flows.size() > 0) flow_step();

    // Drain: all expected items, then a quiet stretch for stray output.
    @(posedge clk);
    in_valid <= 0;
    while (flow_model.expected_items.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (flow_model.mismatches == 0 && flow_model.expected_items.size() == 0) begin
      $display("tb_tcp_flow_statistics_table_unit: clean");
    end else begin
      $display("tb_tcp_flow_statistics_table_unit: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/fsts_pkg.sv
rtl/fsts_ram.sv
rtl/tcp_flow_statistics_table_unit.sv
verif/tb_tcp_flow_statistics_table_unit.sv
